/* hw/rtl/fbba_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package fbba_pkg;

	typedef enum logic [2:0] {
		OP_MARK_USED  = 3'd0,
		OP_MARK_FREE  = 3'd1,
		OP_FIRST_FREE = 3'd2,
		OP_COUNT_RUN  = 3'd3,
		OP_FIND_RUN   = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		VAL_ZERO,
		VAL_POS,
		VAL_RUN,
		VAL_START
	} val_sel_t;

	typedef enum logic [3:0] {
		S_START,
		S_INIT,
		S_IDLE,
		S_DISP,
		S_MWR,
		S_FF,
		S_RUN,
		S_RUNEND,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic     init_start;
		logic     init_step;
		logic     capture;
		logic     p_zero;
		logic     p_inc;
		logic     r_inc;
		logic     set_start;
		logic     rd;
		logic     mark_wr;
		logic     set_res;
		logic     res_found;
		val_sel_t res_sel;
		logic     emit;
	} ctl_cmd_t;

	typedef struct packed {
		op_t  op;
		logic cnt_zero;
		logic want_bad;
		logic need_zero;
		logic in_range;
		logic hit;
		logic bit_free;
		logic boundary;
		logic r1_ge;
		logic r_ge;
		logic sweep_last;
		logic out_busy;
	} ctl_stat_t;

	localparam logic [15:0] TOTAL_RESET = 16'hffff;
	localparam logic [2:0]  REG_TOTAL   = 3'd0;

endpackage
`default_nettype wire

/* hw/rtl/free_block_bitmap_allocator.sv */
// Marks go from accept through dispatch, map read-modify-write and emit states to the
// result; rejected items go from dispatch to emit. A search walks bit by bit, reading bytes.
// Throughput: one item at a time, set by the bit-serial walk over the byte-wide map RAM.
// Reset (and every total_blocks write) runs an init sweep over the map, one map byte per
// cycle, with in_stall high; total_blocks resets to 65535.
`timescale 1ns / 1ps
`default_nettype none
module free_block_bitmap_allocator #(
	parameter int MAX_BLOCKS = 65536
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  operation,
	input  wire logic [15:0] block,
	input  wire logic [15:0] length,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             found,
	output logic [15:0]      value,
	output logic [15:0]      free_blocks
);

	logic [15:0] total_q;
	logic        cfg_wr;
	fbba_pkg::ctl_cmd_t  cmd;
	fbba_pkg::ctl_stat_t stat;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && !paddr[2];
	assign prdata = paddr[2] ? 32'd0 : {16'd0, total_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= fbba_pkg::TOTAL_RESET;
		end else if (cfg_wr) begin
			total_q <= pwdata[15:0];
		end
	end

	fbba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.cfg_wr   (cfg_wr),
		.stat     (stat),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	fbba_datapath #(.MAX_BLOCKS(MAX_BLOCKS)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.total       (total_q),
		.cmd         (cmd),
		.stat        (stat),
		.operation   (operation),
		.block       (block),
		.length      (length),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.found       (found),
		.value       (value),
		.free_blocks (free_blocks)
	);

endmodule
`default_nettype wire

/* hw/rtl/fbba_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module fbba_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              cfg_wr,
	input  fbba_pkg::ctl_stat_t    stat,
	output fbba_pkg::ctl_cmd_t     cmd,
	output logic                   in_stall
);

	fbba_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fbba_pkg::S_START;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != fbba_pkg::S_IDLE) || cfg_wr;

	always_comb begin
		cmd     = '0;
		cmd.res_sel = fbba_pkg::VAL_ZERO;
		state_d = state_q;
		unique case (state_q)
			fbba_pkg::S_START: begin
				cmd.init_start = 1'b1;
				state_d = fbba_pkg::S_INIT;
			end
			fbba_pkg::S_INIT: begin
				cmd.init_step = 1'b1;
				if (stat.sweep_last) state_d = fbba_pkg::S_IDLE;
			end
			fbba_pkg::S_IDLE: begin
				if (in_valid && !cfg_wr) begin
					cmd.capture = 1'b1;
					state_d = fbba_pkg::S_DISP;
				end
			end
			fbba_pkg::S_DISP: begin
				state_d = fbba_pkg::S_EMIT;
				cmd.set_res = 1'b1;
				case (stat.op)
					fbba_pkg::OP_MARK_USED, fbba_pkg::OP_MARK_FREE: begin
						if (stat.in_range) begin
							cmd.set_res = 1'b0;
							cmd.rd = 1'b1;
							state_d = fbba_pkg::S_MWR;
						end
					end
					fbba_pkg::OP_FIRST_FREE: begin
						if (stat.in_range && !stat.cnt_zero) begin
							cmd.set_res = 1'b0;
							state_d = fbba_pkg::S_FF;
						end
					end
					fbba_pkg::OP_COUNT_RUN: begin
						if (stat.in_range && !stat.cnt_zero) begin
							cmd.set_res = 1'b0;
							state_d = fbba_pkg::S_RUN;
						end
					end
					fbba_pkg::OP_FIND_RUN: begin
						if (!stat.want_bad) begin
							cmd.set_res = 1'b0;
							cmd.p_zero = 1'b1;
							state_d = fbba_pkg::S_FF;
						end
					end
					default: ;
				endcase
			end
			fbba_pkg::S_MWR: begin
				cmd.mark_wr   = 1'b1;
				cmd.set_res   = 1'b1;
				cmd.res_found = 1'b1;
				state_d = fbba_pkg::S_EMIT;
			end
			fbba_pkg::S_FF: begin
				if (!stat.in_range) begin
					cmd.set_res = 1'b1;
					state_d = fbba_pkg::S_EMIT;
				end else if (!stat.hit) begin
					cmd.rd = 1'b1;
				end else if (stat.bit_free) begin
					if (stat.op == fbba_pkg::OP_FIND_RUN && !stat.need_zero) begin
						cmd.set_start = 1'b1;
						cmd.p_inc = 1'b1;
						state_d = fbba_pkg::S_RUN;
					end else begin
						cmd.set_res   = 1'b1;
						cmd.res_found = 1'b1;
						cmd.res_sel   = fbba_pkg::VAL_POS;
						state_d = fbba_pkg::S_EMIT;
					end
				end else begin
					cmd.p_inc = 1'b1;
				end
			end
			fbba_pkg::S_RUN: begin
				if (stat.in_range && !stat.hit) begin
					cmd.rd = 1'b1;
				end else if (stat.in_range && stat.bit_free) begin
					cmd.r_inc = 1'b1;
					if (stat.boundary && stat.r1_ge) state_d = fbba_pkg::S_RUNEND;
					else cmd.p_inc = 1'b1;
				end else begin
					state_d = fbba_pkg::S_RUNEND;
				end
			end
			fbba_pkg::S_RUNEND: begin
				if (stat.op == fbba_pkg::OP_COUNT_RUN) begin
					cmd.set_res   = 1'b1;
					cmd.res_found = 1'b1;
					cmd.res_sel   = fbba_pkg::VAL_RUN;
					state_d = fbba_pkg::S_EMIT;
				end else if (stat.r_ge) begin
					cmd.set_res   = 1'b1;
					cmd.res_found = 1'b1;
					cmd.res_sel   = fbba_pkg::VAL_START;
					state_d = fbba_pkg::S_EMIT;
				end else begin
					state_d = fbba_pkg::S_FF;
				end
			end
			fbba_pkg::S_EMIT: begin
				if (!stat.out_busy) begin
					cmd.emit = 1'b1;
					state_d = fbba_pkg::S_IDLE;
				end
			end
			default: state_d = fbba_pkg::S_START;
		endcase
		if (cfg_wr) begin
			cmd     = '0;
			cmd.res_sel = fbba_pkg::VAL_ZERO;
			state_d = fbba_pkg::S_START;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/fbba_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
module fbba_datapath #(
	parameter int MAX_BLOCKS = 65536
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [15:0]    total,
	input  fbba_pkg::ctl_cmd_t  cmd,
	output fbba_pkg::ctl_stat_t stat,
	input  wire logic [2:0]     operation,
	input  wire logic [15:0]    block,
	input  wire logic [15:0]    length,
	input  wire logic           out_stall,
	output logic                out_valid,
	output logic                found,
	output logic [15:0]         value,
	output logic [15:0]         free_blocks
);

	localparam int WORDS = (MAX_BLOCKS + 7) / 8;
	localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam logic [16:0] MAXB = 17'(MAX_BLOCKS);
	localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);

	logic [7:0] mem [WORDS];

	fbba_pkg::op_t op_q;
	logic [15:0]   len_q;
	logic [16:0]   p_q;
	logic [16:0]   r_q;
	logic [15:0]   start_q;
	logic [15:0]   count_q;
	logic [AW-1:0] sweep_q;
	logic [7:0]    rdata_q;
	logic          loaded_q;
	logic [AW-1:0] laddr_q;
	logic          res_found_q;
	logic [15:0]   res_value_q;

	logic [16:0]   n;
	logic [AW-1:0] addr;
	logic [16:0]   base;
	logic [16:0]   nk;
	logic [7:0]    init_byte;
	logic [7:0]    mask;
	logic          was_free;
	logic [15:0]   lim;
	logic [16:0]   r1;
	logic [15:0]   res_value_d;

	assign n    = ({1'b0, total} > MAXB) ? MAXB : {1'b0, total};
	assign addr = p_q[AW+2:3];
	assign base = {{(14-AW){1'b0}}, sweep_q, 3'b000};
	assign nk   = n - base;

	always_comb begin
		if (base >= n) init_byte = 8'h00;
		else if (nk >= 17'd8) init_byte = 8'hff;
		else init_byte = ~(8'hff >> nk[2:0]);
	end

	assign mask     = 8'h80 >> p_q[2:0];
	assign was_free = (rdata_q & mask) != 8'h00;
	assign lim      = (op_q == fbba_pkg::OP_FIND_RUN) ? (len_q - 16'd1) : len_q;
	assign r1       = r_q + 17'd1;

	always_comb begin
		case (cmd.res_sel)
			fbba_pkg::VAL_POS:   res_value_d = p_q[15:0];
			fbba_pkg::VAL_RUN:   res_value_d = r_q[15:0];
			fbba_pkg::VAL_START: res_value_d = start_q;
			default:             res_value_d = 16'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.init_step) begin
			mem[sweep_q] <= init_byte;
		end else if (cmd.mark_wr) begin
			mem[addr] <= (op_q == fbba_pkg::OP_MARK_USED) ? (rdata_q & ~mask) : (rdata_q | mask);
		end
		if (cmd.rd) rdata_q <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q  <= 1'b0;
			sweep_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.init_start) sweep_q <= '0;
			else if (cmd.init_step) sweep_q <= sweep_q + AW'(1);
			if (cmd.init_start || cmd.mark_wr) loaded_q <= 1'b0;
			else if (cmd.rd) loaded_q <= 1'b1;
			if (cmd.emit) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init_start) count_q <= n[15:0];
		else if (cmd.mark_wr) begin
			if (op_q == fbba_pkg::OP_MARK_USED && was_free) count_q <= count_q - 16'd1;
			else if (op_q == fbba_pkg::OP_MARK_FREE && !was_free) count_q <= count_q + 16'd1;
		end
		if (cmd.rd) laddr_q <= addr;
		if (cmd.capture) begin
			op_q  <= fbba_pkg::op_t'(operation);
			len_q <= length;
			p_q   <= {1'b0, block};
			r_q   <= '0;
		end else begin
			if (cmd.p_zero) p_q <= '0;
			else if (cmd.p_inc) p_q <= p_q + 17'd1;
			if (cmd.set_start) r_q <= '0;
			else if (cmd.r_inc) r_q <= r1;
		end
		if (cmd.set_start) start_q <= p_q[15:0];
		if (cmd.set_res) begin
			res_found_q <= cmd.res_found;
			res_value_q <= res_value_d;
		end
		if (cmd.emit) begin
			found       <= res_found_q;
			value       <= res_value_q;
			free_blocks <= count_q;
		end
	end

	always_comb begin
		stat.op         = op_q;
		stat.cnt_zero   = count_q == 16'd0;
		stat.want_bad   = (len_q == 16'd0) || (len_q > count_q);
		stat.need_zero  = len_q == 16'd1;
		stat.in_range   = p_q < n;
		stat.hit        = loaded_q && (laddr_q == addr);
		stat.bit_free   = rdata_q[3'd7 - p_q[2:0]];
		stat.boundary   = p_q[2:0] == 3'd7;
		stat.r1_ge      = r1 >= {1'b0, lim};
		stat.r_ge       = r_q >= {1'b0, lim};
		stat.sweep_last = sweep_q == LAST_WORD;
		stat.out_busy   = out_valid && out_stall;
	end

endmodule
`default_nettype wire

/* hw/rtl/fbba_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module fbba_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        psel,
	input wire logic        penable,
	input wire logic        pwrite,
	input wire logic [2:0]  paddr,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        found,
	input wire logic [15:0] value,
	input wire logic [15:0] free_blocks
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(found) && $stable(value)
			&& $stable(free_blocks))
		else $error("stalled result changed");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("item accepted while previous item in work");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> value == 16'd0)
		else $error("not-found result carries nonzero value");

	a_init: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && !paddr[2] |=> in_stall)
		else $error("item accepted during map init");

endmodule

bind free_block_bitmap_allocator fbba_checker u_fbba_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.psel        (psel),
	.penable     (penable),
	.pwrite      (pwrite),
	.paddr       (paddr),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.found       (found),
	.value       (value),
	.free_blocks (free_blocks)
);
`default_nettype wire
